// File: hdl/lz_bitstream_decoder_m4_unit_assert.svh
// Assertion macros for the ARJ method 4 decoder.
`ifndef LZ_BITSTREAM_DECODER_M4_UNIT_ASSERT_SVH
`define LZ_BITSTREAM_DECODER_M4_UNIT_ASSERT_SVH
// Check that a condition implies another on the same edge.
`define LZD_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("label failed");
// Check that a condition implies another on the next edge.
`define LZD_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("label failed");
`endif

// File: hdl/lzd_pkg.sv
// Types and constants shared by the ARJ method 4 decoder.
`timescale 1ns / 1ps
package lzd_pkg;
  typedef enum logic [2:0] {
    PH_FLAG, PH_LPRE, PH_LBITS, PH_DPRE, PH_DBITS
  } phase_t;
  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_COPY_RD, ST_COPY_WT, ST_FLUSH
  } ctl_state_t;
  localparam int LEN_PRE_MAX = 7;
  localparam int DIST_PRE_MAX = 4;
  localparam int DIST_BASE_BITS = 9;
endpackage

// File: hdl/lzd_stream_if.sv
// Valid/ready stream interface with a generic payload.
`timescale 1ns / 1ps
interface lzd_stream_if #(parameter int W = 8) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/lz_bitstream_decoder_m4_unit.sv
// Top level of the ARJ method 4 decoder: bit parser, window copy, output packer.
//   channel | dir | payload
//   in_ch   | in  | data_byte[7:0]
//   out_ch  | out | out_byte0..N, byte_count, last_of_run, stream_done
// A byte is accepted, then decoded one step at a time (flag, prefix bit or field)
// until its bits run out, and the bytes it gives are then flushed. A match copies
// each byte by a window read, then a write back; a full beat in a copy is flushed
// before the copy goes on, and a flush waits while the sink holds the previous beat.
// Synchronous reset clears control state; the window is not cleared. Input waits
// while a byte is in work; after the stream ends bytes are taken and dropped.
`timescale 1ns / 1ps
module lz_bitstream_decoder_m4_unit #(
  parameter int WINDOW_DEPTH = 16384,
  parameter int OUT_LANES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  lzd_stream_if.sink   in_ch,
  lzd_stream_if.source out_ch
);
  import lzd_pkg::*;
  `include "lz_bitstream_decoder_m4_unit_assert.svh"
  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int LW = $clog2(OUT_LANES + 1);

  ctl_state_t  state, state_next;
  phase_t      phase;
  logic [31:0] acc;
  logic [5:0]  held;
  logic [31:0] remaining;
  logic [8:0]  mlen;
  logic [15:0] mdist;
  logic [AW-1:0] wpos;
  logic [7:0]  lane [OUT_LANES];
  logic [LW-1:0] lcnt;
  logic        ob_valid;
  logic [7:0]  ob_byte [OUT_LANES];
  logic [2:0]  ob_cnt;
  logic        ob_last, ob_done;

  logic        ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]  ram_rdata;
  logic [7:0]  wbyte;

  lzd_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_win (
    .clk(clk), .we(ram_we), .waddr(wpos), .wdata(wbyte),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // decode helpers
  logic        top_bit;
  logic [5:0]  hm1;
  logic [31:0] field;
  logic [5:0]  need;
  assign hm1 = held - 6'd1;
  assign top_bit = acc[hm1[4:0]];
  always_comb begin
    unique case (phase)
      PH_LBITS: need = 6'(mlen[2:0]);
      PH_DBITS: need = 6'(mdist[2:0]) + 6'(DIST_BASE_BITS);
      default:  need = 6'd9;
    endcase
    field = (acc >> (held - need)) & ((32'd1 << need) - 32'd1);
  end

  logic out_full;
  assign out_full = ob_valid && !out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = ob_valid;
  always_comb begin
    out_ch.data = '0;
    for (int k = 0; k < OUT_LANES; k++) out_ch.data[8*k +: 8] = ob_byte[k];
    out_ch.data[8*OUT_LANES +: 3] = ob_cnt;
    out_ch.data[8*OUT_LANES+3] = ob_last;
    out_ch.data[8*OUT_LANES+4] = ob_done;
  end

  // a byte completes one token at most, so only an unfinished copy adds a beat
  logic more;
  assign more = (lcnt == LW'(OUT_LANES)) && remaining != 32'd0 && mlen != 9'd0;

  logic emit;
  always_comb begin
    state_next = state;
    ram_we = 1'b0;
    wbyte = field[7:0];
    ram_raddr = wpos - AW'(mdist) - AW'(1);
    emit = 1'b0;
    unique case (state)
      ST_IDLE: if (in_ch.valid && remaining != 32'd0) state_next = ST_DECODE;
      ST_DECODE: begin
        if (lcnt == LW'(OUT_LANES)) state_next = ST_FLUSH;
        else if (remaining == 32'd0) state_next = ST_FLUSH;
        else if (phase == PH_FLAG && held != 0 && !top_bit && held >= 6'd9) begin
          ram_we = 1'b1; emit = 1'b1;
        end else if (phase == PH_DBITS && held >= need) state_next = ST_COPY_RD;
        else if ((phase == PH_FLAG && held == 0) ||
                 (phase == PH_FLAG && !top_bit && held < 6'd9) ||
                 ((phase == PH_LPRE || phase == PH_DPRE) && held == 0 &&
                  !(phase == PH_LPRE && mlen >= 9'(LEN_PRE_MAX)) &&
                  !(phase == PH_DPRE && mdist >= 16'(DIST_PRE_MAX))) ||
                 (phase == PH_LBITS && held < need) ||
                 (phase == PH_DBITS && held < need))
          state_next = ST_FLUSH;
      end
      ST_COPY_RD: begin
        if (lcnt == LW'(OUT_LANES)) state_next = ST_FLUSH;
        else if (mlen == 0 || remaining == 32'd0) state_next = ST_DECODE;
        else state_next = ST_COPY_WT;
      end
      ST_COPY_WT: begin
        wbyte = ram_rdata; ram_we = 1'b1; emit = 1'b1;
        state_next = ST_COPY_RD;
      end
      ST_FLUSH: if (!out_full) begin
        if (more) state_next = ST_COPY_RD;
        else state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; phase <= PH_FLAG; acc <= '0; held <= '0;
      remaining <= 32'd1; mlen <= '0; mdist <= '0; wpos <= '0;
      lcnt <= '0; ob_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FLUSH && !out_full && lcnt != '0) ob_valid <= 1'b1;
      else if (out_ch.ready) ob_valid <= 1'b0;
      if (cfg_we) remaining <= cfg_wdata;
      else if (emit) remaining <= remaining - 32'd1;
      if (emit) begin
        lane[lcnt[$clog2(OUT_LANES)-1:0]] <= wbyte;
        lcnt <= lcnt + LW'(1);
        wpos <= wpos + AW'(1);
      end
      unique case (state)
        // drop the byte once the stream has ended
        ST_IDLE: if (in_ch.valid && remaining != 32'd0) begin
          acc <= {acc[23:0], in_ch.data[7:0]};
          held <= held + 6'd8;
        end
        ST_DECODE: if (state_next == ST_DECODE) begin
          unique case (phase)
            PH_FLAG: if (!top_bit) begin
              held <= held - 6'd9;
            end else begin
              held <= hm1; mlen <= 9'd1; phase <= PH_LPRE;
            end
            PH_LPRE: if (mlen >= 9'(LEN_PRE_MAX)) phase <= PH_LBITS;
              else begin
                held <= hm1;
                if (!top_bit) phase <= PH_LBITS; else mlen <= mlen + 9'd1;
              end
            PH_LBITS: begin
              held <= held - need;
              mlen <= 9'((32'd1 << need) + field + 32'd1);
              mdist <= '0; phase <= PH_DPRE;
            end
            PH_DPRE: if (mdist >= 16'(DIST_PRE_MAX)) phase <= PH_DBITS;
              else begin
                held <= hm1;
                if (!top_bit) phase <= PH_DBITS; else mdist <= mdist + 16'd1;
              end
            default: phase <= PH_FLAG;
          endcase
        end else if (state_next == ST_COPY_RD) begin
          held <= held - need;
          mdist <= 16'((((32'd1 << mdist[2:0]) - 32'd1) << DIST_BASE_BITS) + field);
          phase <= PH_FLAG;
        end
        ST_COPY_RD: if (state_next == ST_DECODE) mlen <= '0;
        ST_COPY_WT: mlen <= mlen - 9'd1;
        ST_FLUSH: if (!out_full) begin
          if (lcnt != '0) begin
            for (int k = 0; k < OUT_LANES; k++)
              ob_byte[k] <= (LW'(k) < lcnt) ? lane[k] : 8'd0;
            ob_cnt <= 3'(lcnt);
            ob_last <= !more;
            ob_done <= !more && remaining == 32'd0;
          end
          lcnt <= '0;
          if (remaining == 32'd0) begin
            acc <= '0; held <= '0; phase <= PH_FLAG; mlen <= '0;
          end
        end
        default: ;
      endcase
      if (emit && state == ST_DECODE)
        acc <= acc & ((32'd1 << (held - 6'd9)) - 32'd1);
    end
  end

  `LZD_ASSERT_IMP(a_no_in_busy, clk, rst, state != ST_IDLE, !in_ch.ready)
  `LZD_ASSERT_IMP(a_cnt_ok, clk, rst, out_ch.valid, ob_cnt != 3'd0)
  `LZD_ASSERT_NEXT(a_hold_out, clk, rst, out_ch.valid && !out_ch.ready,
                   out_ch.valid && $stable(ob_cnt))
endmodule

// File: hdl/lzd_ram.sv
// Generic simple dual-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: test/lz_bitstream_decoder_m4_unit_tb.sv
// Testbench for the ARJ method 4 decoder: directed table, random token streams, scoreboard.
`timescale 1ns / 1ps
module lz_bitstream_decoder_m4_unit_tb;
  import lzd_pkg::*;

  localparam int WIN = 16384;
  localparam int LANES = 4;
  localparam int QUIET_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 380;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic       done;
    logic       last;
    logic [2:0] cnt;
    logic [7:0] b3;
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
  } beat_t;

  typedef enum {ROW_BYTE, ROW_CFG, ROW_LIT, ROW_MATCH} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] val;
    bit          has_exp;
    beat_t       exp;
    int          n;
    int          v;
    int          j;
    int          w;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  lzd_stream_if #(.W(8)) in_if (clk);
  lzd_stream_if #(.W($bits(beat_t))) out_if (clk);

  lz_bitstream_decoder_m4_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_if),
    .out_ch(out_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Decoder image
  logic [7:0]  win_mem [0:WIN-1];
  int unsigned wr_pos, acc, held, left_cnt, mlen, mdist;
  phase_t      ph;
  logic [7:0]  step_bytes [$];
  beat_t       pending_beats [$];
  int unsigned tot_written;

  // Token generator
  bit          gen_bits [$];
  longint unsigned gen_left;
  int unsigned gen_written;

  int errors = 0;
  int items = 0;
  int beats_seen = 0;
  int matches_sent = 0;
  int phases = 0;
  int idle_pct = 22;
  int hold_cnt = 0;
  int quiet = 0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int unsigned take_bits(input int unsigned k);
    int unsigned v;
    v = (acc >> (held - k)) & ((32'd1 << k) - 1);
    held -= k;
    acc = (held == 0) ? 0 : (acc & ((32'd1 << held) - 1));
    return v;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    if (left_cnt == 0) return;
    win_mem[wr_pos] = b;
    wr_pos = (wr_pos + 1) % WIN;
    step_bytes.push_back(b);
    left_cnt--;
    tot_written++;
  endfunction

  function automatic bit decode_step();
    int unsigned n, back, src;
    case (ph)
      PH_FLAG: begin
        if (held < 1) return 0;
        if (((acc >> (held - 1)) & 1) == 0) begin
          if (held < 9) return 0;
          put_byte(8'(take_bits(9)));
          return 1;
        end
        void'(take_bits(1));
        mlen = 1;
        ph = PH_LPRE;
        return 1;
      end
      PH_LPRE: begin
        if (mlen >= LEN_PRE_MAX) begin
          ph = PH_LBITS;
          return 1;
        end
        if (held < 1) return 0;
        if (take_bits(1) == 0) ph = PH_LBITS;
        else mlen++;
        return 1;
      end
      PH_LBITS: begin
        n = (mlen > LEN_PRE_MAX) ? LEN_PRE_MAX : mlen;
        if (held < n) return 0;
        mlen = (32'd1 << n) + take_bits(n) + 1;
        mdist = 0;
        ph = PH_DPRE;
        return 1;
      end
      PH_DPRE: begin
        if (mdist >= DIST_PRE_MAX) begin
          ph = PH_DBITS;
          return 1;
        end
        if (held < 1) return 0;
        if (take_bits(1) == 0) ph = PH_DBITS;
        else mdist++;
        return 1;
      end
      PH_DBITS: begin
        n = (mdist > DIST_PRE_MAX) ? DIST_PRE_MAX : mdist;
        if (held < n + DIST_BASE_BITS) return 0;
        mdist = (((32'd1 << n) - 1) << DIST_BASE_BITS) + take_bits(n + DIST_BASE_BITS);
        back = mdist + 1;
        for (int unsigned k = 0; k < mlen && left_cnt != 0; k++) begin
          src = (wr_pos + WIN - (back % WIN)) % WIN;
          put_byte(win_mem[src]);
        end
        ph = PH_FLAG;
        return 1;
      end
      default: begin
        ph = PH_FLAG;
        return 1;
      end
    endcase
  endfunction

  // Run one accepted byte through the image; returns the number of beats queued.
  function automatic int predict_beats(input logic [7:0] d);
    int    nres, cnt;
    bit    fin;
    beat_t bt;
    if (left_cnt == 0) return 0;
    items++;
    step_bytes.delete();
    acc = (acc << 8) | d;
    held += 8;
    while (left_cnt != 0 && decode_step()) begin
    end
    fin = (left_cnt == 0);
    if (fin) begin
      acc = 0;
      held = 0;
      ph = PH_FLAG;
    end
    nres = (step_bytes.size() + LANES - 1) / LANES;
    for (int r = 0; r < nres; r++) begin
      cnt = step_bytes.size() - r * LANES;
      if (cnt > LANES) cnt = LANES;
      bt = '0;
      bt.b0 = step_bytes[r*LANES];
      if (cnt > 1) bt.b1 = step_bytes[r*LANES+1];
      if (cnt > 2) bt.b2 = step_bytes[r*LANES+2];
      if (cnt > 3) bt.b3 = step_bytes[r*LANES+3];
      bt.cnt = 3'(cnt);
      bt.last = (r + 1 == nres);
      bt.done = (r + 1 == nres) && fin;
      pending_beats.push_back(bt);
    end
    return nres;
  endfunction

  // Offer one byte; hold valid until it is taken.
  task automatic send_byte(input logic [7:0] d, output int nres);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= d;
    do @(posedge clk); while (!in_if.ready);
    nres = predict_beats(d);
  endtask

  task automatic drain();
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [31:0] v);
    @(negedge clk);
    in_if.valid <= 1'b0;
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    left_cnt = v;
    gen_left = v;
    if (gen_bits.size() == 0) gen_written = (tot_written > WIN) ? WIN : tot_written;
    phases++;
  endtask

  task automatic push_bits(input int unsigned v, input int nb);
    for (int i = nb - 1; i >= 0; i--) gen_bits.push_back(v[i]);
  endtask

  task automatic flush_bytes();
    logic [7:0] b;
    int nres;
    while (gen_bits.size() >= 8) begin
      for (int i = 0; i < 8; i++) b = {b[6:0], gen_bits.pop_front()};
      send_byte(b, nres);
    end
  endtask

  task automatic account(input int unsigned len);
    longint unsigned got;
    got = (len < gen_left) ? len : gen_left;
    gen_left -= got;
    gen_written = (gen_written + got > WIN) ? WIN : gen_written + got;
    flush_bytes();
    if (gen_left == 0 && gen_bits.size() != 0) begin
      // tail bits after the final token are dropped by the block
      while (gen_bits.size() % 8 != 0) gen_bits.push_back($urandom_range(0, 1));
      flush_bytes();
    end
  endtask

  task automatic send_literal(input logic [7:0] b);
    push_bits(0, 1);
    push_bits(b, 8);
    account(1);
  endtask

  task automatic send_match(input int n, input int v, input int j, input int w);
    push_bits(1, 1);
    for (int i = 1; i < n; i++) push_bits(1, 1);
    if (n < LEN_PRE_MAX) push_bits(0, 1);
    push_bits(v, n);
    for (int i = 0; i < j; i++) push_bits(1, 1);
    if (j < DIST_PRE_MAX) push_bits(0, 1);
    push_bits(w, j + DIST_BASE_BITS);
    matches_sent++;
    account((1 << n) + v + 1);
  endtask

  // Random token whose source always lies in written history.
  task automatic send_random_token();
    int n, v, j, w, jmax, wmax;
    if (gen_written == 0 || $urandom_range(0, 99) < 35) begin
      send_literal(8'($urandom));
      return;
    end
    n = ($urandom_range(0, 1) == 1) ? LEN_PRE_MAX : $urandom_range(1, LEN_PRE_MAX - 1);
    v = $urandom_range(0, (1 << n) - 1);
    jmax = 0;
    while (jmax < DIST_PRE_MAX && ((1 << (jmax + 1)) - 1) * 512 + 1 <= gen_written) jmax++;
    j = $urandom_range(0, jmax);
    wmax = gen_written - ((1 << j) - 1) * 512 - 1;
    if (wmax > (1 << (j + DIST_BASE_BITS)) - 1) wmax = (1 << (j + DIST_BASE_BITS)) - 1;
    w = ($urandom_range(0, 3) == 0) ? wmax : $urandom_range(0, wmax);
    send_match(n, v, j, w);
  endtask

  // Close a stream that will not end on its own on a byte boundary.
  task automatic align_stream();
    while (gen_bits.size() != 0 && gen_left != 0) send_literal(8'($urandom));
  endtask

  function automatic beat_t mk(input logic [7:0] b0, input logic [2:0] c,
                               input logic l, input logic d);
    beat_t bt;
    bt = '0;
    bt.b0 = b0;
    bt.cnt = c;
    bt.last = l;
    bt.done = d;
    return bt;
  endfunction

  // Output side: random ready, with a long hold when asked.
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_if.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    beat_t got, want;
    if (!rst && out_if.valid && out_if.ready) begin
      got = out_if.data;
      beats_seen++;
      if (pending_beats.size() == 0) begin
        report($sformatf("unexpected beat %h", got));
      end else begin
        want = pending_beats.pop_front();
        if (got.cnt !== want.cnt) report($sformatf("byte_count %0d exp %0d", got.cnt, want.cnt));
        if (got.b0 !== want.b0) report($sformatf("out_byte0 %h exp %h", got.b0, want.b0));
        if (got.b1 !== want.b1) report($sformatf("out_byte1 %h exp %h", got.b1, want.b1));
        if (got.b2 !== want.b2) report($sformatf("out_byte2 %h exp %h", got.b2, want.b2));
        if (got.b3 !== want.b3) report($sformatf("out_byte3 %h exp %h", got.b3, want.b3));
        if (got.last !== want.last) report($sformatf("last_of_run %b exp %b", got.last, want.last));
        if (got.done !== want.done) report($sformatf("stream_done %b exp %b", got.done, want.done));
      end
    end
  end

  // Watchdog: end the run after a long stretch with no traffic.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we || rst)
      quiet <= 0;
    else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  initial begin
    row_t rows [$];
    int   nres, sel, ntok, goal;
    bit   held_once;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    wr_pos = 0; acc = 0; held = 0; left_cnt = 1; mlen = 0; mdist = 0;
    ph = PH_FLAG; tot_written = 0; gen_left = 1; gen_written = 0;
    held_once = 0;

    // Reset size of one: a single literal ends the stream, the rest is ignored.
    rows.push_back('{ROW_BYTE, 8'h7F, 0, '0, 0, 0, 0, 0});
    rows.push_back('{ROW_BYTE, 8'h80, 1, mk(8'hFF, 1, 1, 1), 0, 0, 0, 0});
    rows.push_back('{ROW_BYTE, 8'h55, 0, '0, 0, 0, 0, 0});
    rows.push_back('{ROW_CFG, 32'd0, 0, '0, 0, 0, 0, 0});
    rows.push_back('{ROW_BYTE, 8'hA5, 0, '0, 0, 0, 0, 0});
    rows.push_back('{ROW_CFG, 32'd2, 0, '0, 0, 0, 0, 0});
    rows.push_back('{ROW_BYTE, 8'h00, 0, '0, 0, 0, 0, 0});
    rows.push_back('{ROW_BYTE, 8'h00, 1, mk(8'h00, 1, 1, 0), 0, 0, 0, 0});
    rows.push_back('{ROW_BYTE, 8'h00, 1, mk(8'h00, 1, 1, 1), 0, 0, 0, 0});
    rows.push_back('{ROW_CFG, 32'hFFFF_FFFF, 0, '0, 0, 0, 0, 0});
    rows.push_back('{ROW_LIT, 8'h5A, 0, '0, 0, 0, 0, 0});
    rows.push_back('{ROW_MATCH, 0, 0, '0, 7, 127, 0, 0});
    rows.push_back('{ROW_MATCH, 0, 0, '0, 7, 127, 0, 255});
    rows.push_back('{ROW_LIT, 8'h00, 0, '0, 0, 0, 0, 0});
    rows.push_back('{ROW_LIT, 8'hFF, 0, '0, 0, 0, 0, 0});
    rows.push_back('{ROW_MATCH, 0, 0, '0, 1, 0, 1, 0});
    rows.push_back('{ROW_MATCH, 0, 0, '0, 2, 3, 0, 2});
    rows.push_back('{ROW_CFG, 32'd5, 0, '0, 0, 0, 0, 0});
    rows.push_back('{ROW_MATCH, 0, 0, '0, 7, 127, 0, 0});
    rows.push_back('{ROW_CFG, 32'd1, 0, '0, 0, 0, 0, 0});
    rows.push_back('{ROW_LIT, 8'h81, 0, '0, 0, 0, 0, 0});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_CFG: begin
          align_stream();
          write_size(rows[i].val);
        end
        ROW_BYTE: begin
          send_byte(rows[i].val[7:0], nres);
          if (rows[i].has_exp) begin
            if (nres != 1) report($sformatf("table row %0d gives %0d beats", i, nres));
            else pending_beats[$] = rows[i].exp;
          end
        end
        ROW_LIT: send_literal(rows[i].val[7:0]);
        default: send_match(rows[i].n, rows[i].v, rows[i].j, rows[i].w);
      endcase
    end

    goal = items + RANDOM_ITEMS;
    while (items < goal) begin
      align_stream();
      idle_pct = ($urandom_range(0, 4) == 0) ? 0 : 22;
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        write_size(0);
        repeat (3) send_byte(8'($urandom), nres);
      end else if (sel == 1) begin
        write_size(32'hFFFF_FFFF);
        ntok = $urandom_range(4, 12);
        repeat (ntok) send_random_token();
        align_stream();
      end else begin
        write_size((sel == 2) ? 1 : (sel == 3) ? $urandom_range(1000, 4000)
                                               : $urandom_range(1, 400));
        // first ordinary stream: stall the output long enough to back up the input
        if (!held_once) begin
          held_once = 1;
          hold_cnt = 400;
        end
        while (gen_left != 0) send_random_token();
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom), nres);
      end
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    drain();
    $display("covered %0d decoded input bytes, %0d matches, %0d output beats, %0d streams",
             items, matches_sent, beats_seen, phases);
    $display("history bytes written: %0d, mismatches: %0d", tot_written, errors);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

// File: sim.f
+incdir+hdl
hdl/lzd_pkg.sv
hdl/lzd_stream_if.sv
hdl/lzd_ram.sv
hdl/lz_bitstream_decoder_m4_unit.sv
test/lz_bitstream_decoder_m4_unit_tb.sv
